// ----- rtl/psp_pkg.sv -----
`default_nettype none
package psp_pkg;

	localparam int RING_WORDS_DEF = 1024;

	localparam int SAMPLE_W = 8;
	localparam int WORD_W   = 16;
	localparam int PERIOD_W = 16;
	localparam int POS_W    = 11;
	localparam int FREE_W   = 10;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 32;

	localparam logic [WORD_W-1:0]   MIDSCALE_WORD  = 16'h8080;
	localparam logic [SAMPLE_W-1:0] MIDSCALE_LEVEL = 8'h80;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd1;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic              upd;
		logic              hi;
		logic              dflt;
		logic [POS_W-1:0]  pos;
		logic [FREE_W-1:0] free;
	} s1_t;

endpackage
`default_nettype wire

// ----- rtl/psp_ring_ram.sv -----
`default_nettype none
module psp_ring_ram #(
	parameter int RING_WORDS = psp_pkg::RING_WORDS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [$clog2(RING_WORDS)-1:0]       waddr,
	input  wire logic [psp_pkg::WORD_W-1:0]          wdata,
	input  wire logic                                re,
	input  wire logic [$clog2(RING_WORDS)-1:0]       raddr,
	output logic      [psp_pkg::WORD_W-1:0]          rdata
);
	import psp_pkg::*;

	logic [WORD_W-1:0] mem [RING_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/psp_ctrl.sv -----
`default_nettype none
module psp_ctrl #(
	parameter int RING_WORDS = psp_pkg::RING_WORDS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [psp_pkg::PERIOD_W-1:0]        cfg_wdata,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [psp_pkg::S_DATA_W-1:0]        s_tdata,
	input  wire logic                                s_tuser,
	output logic                                     mem_we,
	output logic      [$clog2(RING_WORDS)-1:0]       mem_waddr,
	output logic      [psp_pkg::WORD_W-1:0]          mem_wdata,
	output logic                                     mem_re,
	output logic      [$clog2(RING_WORDS)-1:0]       mem_raddr,
	output logic                                     v_s1,
	output psp_pkg::s1_t                             ctl_s1,
	input  wire logic                                s1_ready
);
	import psp_pkg::*;

	localparam int WIDX_W = $clog2(RING_WORDS);
	localparam int PIDX_W = WIDX_W + 1;
	localparam logic [WIDX_W-1:0] WR_LAST   = WIDX_W'(RING_WORDS - 1);
	localparam logic [PIDX_W-1:0] PLAY_LAST = PIDX_W'(2 * RING_WORDS - 1);
	localparam logic [WIDX_W:0]   RING_EXT  = (WIDX_W + 1)'(RING_WORDS);

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] cnt_q;
	logic [PIDX_W-1:0]   play_q;
	logic [WIDX_W-1:0]   wr_q;
	logic [WIDX_W:0]     fill_q;

	logic                acc;
	logic                is_wr;
	logic                emit;
	logic [PERIOD_W-1:0] period_eff;
	logic [PERIOD_W-1:0] cnt_inc;
	logic [PERIOD_W-1:0] cnt_n;
	logic [PIDX_W-1:0]   play_n;
	logic [WIDX_W-1:0]   wr_n;
	logic [WIDX_W:0]     fill_n;
	logic [WIDX_W:0]     cur;
	logic [WIDX_W:0]     fw;
	logic [31:0]         pos_ext;
	logic [31:0]         free_ext;
	logic                dflt;

	assign s_tready = !v_s1 || s1_ready;
	assign acc      = s_tvalid && s_tready;
	assign is_wr    = (s_tuser == OP_WRITE);

	always_comb begin
		period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
		cnt_inc    = cnt_q + PERIOD_W'(1);
		emit       = !is_wr && (cnt_inc >= period_eff);
		cnt_n      = cnt_q;
		play_n     = play_q;
		wr_n       = wr_q;
		fill_n     = fill_q;
		if (is_wr) begin
			wr_n = (wr_q == WR_LAST) ? '0 : wr_q + WIDX_W'(1);
			if (fill_q != RING_EXT) begin
				fill_n = fill_q + (WIDX_W + 1)'(1);
			end
		end else if (emit) begin
			cnt_n  = '0;
			play_n = (play_q == PLAY_LAST) ? '0 : play_q + PIDX_W'(1);
		end else begin
			cnt_n = cnt_inc;
		end
		cur = {1'b0, play_n[PIDX_W-1:1]};
		if (cur < {1'b0, wr_n}) begin
			cur = cur + RING_EXT;
		end
		fw       = cur - {1'b0, wr_n};
		pos_ext  = 32'(play_n);
		free_ext = 32'(fw);
		dflt     = {1'b0, play_q[PIDX_W-1:1]} >= fill_q;
	end

	assign mem_we    = acc && is_wr;
	assign mem_waddr = wr_q;
	assign mem_wdata = s_tdata[WORD_W-1:0];
	assign mem_re    = acc && emit;
	assign mem_raddr = play_q[PIDX_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			play_q <= '0;
			wr_q   <= '0;
			fill_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q  <= cnt_n;
				play_q <= play_n;
				wr_q   <= wr_n;
				fill_q <= fill_n;
				v_s1   <= 1'b1;
			end else if (s1_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1.upd  <= emit;
			ctl_s1.hi   <= play_q[0];
			ctl_s1.dflt <= dflt;
			ctl_s1.pos  <= pos_ext[POS_W-1:0];
			ctl_s1.free <= free_ext[FREE_W-1:0];
		end
	end

`ifndef ASSERT_OFF
	a_play_range: assert property (@(posedge clk) disable iff (!arst_n)
		play_q <= PLAY_LAST)
		else $error("play index out of ring");
	a_fill_track: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < RING_EXT |-> {1'b0, wr_q} == fill_q)
		else $error("write index and fill count disagree");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= RING_EXT)
		else $error("fill count above ring size");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_ready |=> v_s1 && $stable(ctl_s1))
		else $error("stage one lost while stalled");
`endif

endmodule
`default_nettype wire

// ----- rtl/psp_out.sv -----
`default_nettype none
module psp_out (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                v_s1,
	input  wire psp_pkg::s1_t                        ctl_s1,
	input  wire logic [psp_pkg::WORD_W-1:0]          rdata,
	output logic                                     s1_ready,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [psp_pkg::M_DATA_W-1:0]        m_tdata,
	output logic                                     m_tuser
);
	import psp_pkg::*;

	logic [SAMPLE_W-1:0] dac_q;
	logic [SAMPLE_W-1:0] level;
	logic [WORD_W-1:0]   word;
	logic                adv;

	assign s1_ready = !m_tvalid || m_tready;
	assign adv      = v_s1 && s1_ready;

	always_comb begin
		word  = ctl_s1.dflt ? MIDSCALE_WORD : rdata;
		level = dac_q;
		if (ctl_s1.upd) begin
			level = ctl_s1.hi ? word[WORD_W-1:SAMPLE_W] : word[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dac_q    <= MIDSCALE_LEVEL;
			m_tvalid <= 1'b0;
		end else begin
			if (adv) begin
				dac_q    <= level;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {3'b000, ctl_s1.free, ctl_s1.pos, level};
			m_tuser <= ctl_s1.upd;
		end
	end

`ifndef ASSERT_OFF
	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !ctl_s1.upd |=> $stable(dac_q))
		else $error("level moved without a sample");
	a_out_level: assert property (@(posedge clk) disable iff (!arst_n)
		$past(adv) |-> m_tdata[SAMPLE_W-1:0] == dac_q)
		else $error("result level differs from held level");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire

// ----- rtl/packed_sample_playback_fifo.sv -----
`default_nettype none
// Plays 8-bit samples packed two to a 16-bit word from a ring of RING_WORDS words. Input
// words on s_* are either a tick (s_tuser = 0) or a ring write (s_tuser = 1, s_tdata = word);
// every input word yields one result word on m_*. It takes one word per cycle unless
// m_tready stalls it; a taken word is registered with the ring read, then in the output
// register. The ring reads as midscale 0x8080 until each entry is first written; a fill
// count tracks this, so no clearing pass follows reset. The user must write sample_period
// through cfg_we/cfg_wdata while the block is idle; the block does not enforce this.
module packed_sample_playback_fifo #(
	parameter int RING_WORDS = psp_pkg::RING_WORDS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [psp_pkg::PERIOD_W-1:0]        cfg_wdata,  // sample_period
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [psp_pkg::S_DATA_W-1:0]        s_tdata,    // sample_word
	input  wire logic                                s_tuser,    // op
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// dac_value[7:0], play_position[18:8], free_words[28:19], zero[31:29]
	output logic      [psp_pkg::M_DATA_W-1:0]        m_tdata,
	output logic                                     m_tuser     // dac_update
);
	import psp_pkg::*;

	localparam int WIDX_W = $clog2(RING_WORDS);

	logic              mem_we;
	logic [WIDX_W-1:0] mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [WIDX_W-1:0] mem_raddr;
	logic [WORD_W-1:0] mem_rdata;
	logic              v_s1;
	s1_t               ctl_s1;
	logic              s1_ready;

	psp_ctrl #(
		.RING_WORDS (RING_WORDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.v_s1      (v_s1),
		.ctl_s1    (ctl_s1),
		.s1_ready  (s1_ready)
	);

	psp_ring_ram #(
		.RING_WORDS (RING_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	psp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s1     (v_s1),
		.ctl_s1   (ctl_s1),
		.rdata    (mem_rdata),
		.s1_ready (s1_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
